FILE: hdl/gn3_pkg.sv
package gn3_pkg;

  localparam int unsigned TableSize = 256;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned Corners   = 8;

  localparam logic [23:0] ScaleReset    = 24'h01_0000;
  localparam logic        RegPointScale = 1'b0;

  // 3.0 in Q2.16, the constant in the smoothstep factor (3 - 2t)
  localparam logic [17:0] SmoothThree = 18'd196608;
  localparam logic [16:0] UnitQ16     = 17'h1_0000;

  typedef enum logic [2:0] {
    ReqLoadX    = 3'd0,
    ReqLoadY    = 3'd1,
    ReqLoadZ    = 3'd2,
    ReqLoadGrad = 3'd3,
    ReqEval     = 3'd4
  } req_e;

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } grad_t;

  typedef struct packed {
    logic [2:0]        req;
    logic [7:0]        index;
    logic [7:0]        entry;
    grad_t             grad;
    logic [2:0][31:0]  point;
  } item_t;

  typedef struct packed {
    logic [2:0]            req;
    idx_t                  index;
    grad_t                 grad;
    logic [2:0][1:0][7:0]  perm;
    logic [2:0][15:0]      frac;
    logic [2:0][31:0]      fsq;
    logic [2:0][17:0]      tpoly;
  } front_t;

  typedef struct packed {
    logic [Corners-1:0][16:0] weight;
    logic [Corners-1:0][35:0] dot;
  } corner_t;

endpackage

FILE: hdl/gn3_front.sv
module gn3_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  gn3_pkg::item_t    item_i,
  input  logic [23:0]       scale_i,
  output logic              valid_o,
  output gn3_pkg::front_t   data_o
);

  logic             a_v_q;
  gn3_pkg::item_t   a_q;

  logic             b_v_q;
  logic [2:0]       b_req_q;
  gn3_pkg::idx_t    b_idx_q;
  logic [7:0]       b_entry_q;
  gn3_pkg::grad_t   b_grad_q;
  logic [2:0][56:0] b_prod_q;
  logic [2:0][56:0] b_prod_d;

  logic             c_v_q;
  gn3_pkg::front_t  c_q;

  logic [7:0] perm_mem [3][gn3_pkg::TableSize];

  gn3_pkg::idx_t [2:0] cell0;
  gn3_pkg::idx_t [2:0] cell1;
  logic [2:0][15:0]    frac;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      b_prod_d[d] = $signed({{25{a_q.point[d][31]}}, a_q.point[d]}) *
                    $signed({33'd0, scale_i});
      // floor of the Q.32 product taken modulo the table size
      cell0[d] = b_prod_q[d][32 +: gn3_pkg::IdxW];
      cell1[d] = cell0[d] + 1'b1;
      frac[d]  = b_prod_q[d][31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q       <= item_i;
      b_req_q   <= a_q.req;
      b_idx_q   <= gn3_pkg::idx_t'(a_q.index);
      b_entry_q <= a_q.entry;
      b_grad_q  <= a_q.grad;
      b_prod_q  <= b_prod_d;

      c_q.req   <= b_req_q;
      c_q.index <= b_idx_q;
      c_q.grad  <= b_grad_q;
      for (int d = 0; d < 3; d++) begin
        c_q.perm[d][0] <= perm_mem[d][cell0[d]];
        c_q.perm[d][1] <= perm_mem[d][cell1[d]];
        c_q.frac[d]    <= frac[d];
        c_q.fsq[d]     <= {16'd0, frac[d]} * {16'd0, frac[d]};
        c_q.tpoly[d]   <= gn3_pkg::SmoothThree - {1'b0, frac[d], 1'b0};
      end

      // table writes sit in the same stage as the reads to keep item order
      if (b_v_q && b_req_q == gn3_pkg::ReqLoadX) begin
        perm_mem[0][b_idx_q] <= b_entry_q;
      end
      if (b_v_q && b_req_q == gn3_pkg::ReqLoadY) begin
        perm_mem[1][b_idx_q] <= b_entry_q;
      end
      if (b_v_q && b_req_q == gn3_pkg::ReqLoadZ) begin
        perm_mem[2][b_idx_q] <= b_entry_q;
      end
    end
  end

  assign valid_o = c_v_q;
  assign data_o  = c_q;

endmodule

FILE: hdl/gn3_corner.sv
module gn3_corner (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  gn3_pkg::front_t   data_i,
  output logic              valid_o,
  output gn3_pkg::corner_t  data_o
);

  localparam int unsigned Nc = gn3_pkg::Corners;

  gn3_pkg::grad_t grad_mem [Nc][gn3_pkg::TableSize];

  logic                 d_v_q;
  logic [2:0][16:0]     d_s_q;
  logic [2:0][16:0]     s_d;
  logic [2:0][15:0]     d_frac_q;
  gn3_pkg::grad_t [Nc-1:0] d_grad_q;
  gn3_pkg::idx_t [Nc-1:0]  gidx;

  logic                      e_v_q;
  logic [Nc-1:0][16:0]       e_wxy_q;
  logic [Nc-1:0][16:0]       wxy_d;
  logic [Nc-1:0][2:0][33:0]  e_prod_q;
  logic [Nc-1:0][2:0][33:0]  prod_d;
  logic [16:0]               e_sz_q;

  logic                f_v_q;
  gn3_pkg::corner_t    f_q;
  gn3_pkg::corner_t    f_d;

  always_comb begin
    logic [2:0]  kb;
    logic [49:0] sm;
    for (int d = 0; d < 3; d++) begin
      sm     = {18'd0, data_i.fsq[d]} * {32'd0, data_i.tpoly[d]} + 50'h0_8000_0000;
      s_d[d] = sm[48:32];
    end
    for (int k = 0; k < Nc; k++) begin
      kb      = 3'(k);
      gidx[k] = gn3_pkg::idx_t'(data_i.perm[0][kb[2]] ^ data_i.perm[1][kb[1]] ^
                                data_i.perm[2][kb[0]]);
    end
  end

  always_comb begin
    logic [2:0]       kb;
    logic [16:0]      wx;
    logic [16:0]      wy;
    logic [33:0]      wp;
    logic [17:0]      off;
    logic [15:0]      gc;
    for (int k = 0; k < Nc; k++) begin
      kb       = 3'(k);
      wx       = kb[2] ? d_s_q[0] : gn3_pkg::UnitQ16 - d_s_q[0];
      wy       = kb[1] ? d_s_q[1] : gn3_pkg::UnitQ16 - d_s_q[1];
      wp       = {17'd0, wx} * {17'd0, wy} + 34'h8000;
      wxy_d[k] = wp[32:16];
      for (int d = 0; d < 3; d++) begin
        // corner offset in Q1.16: fraction, minus one toward the far corner
        off = {2'b00, d_frac_q[d]} - (kb[2-d] ? 18'h1_0000 : 18'h0_0000);
        unique case (d)
          0:       gc = d_grad_q[k].x;
          1:       gc = d_grad_q[k].y;
          default: gc = d_grad_q[k].z;
        endcase
        prod_d[k][d] = $signed({{18{gc[15]}}, gc}) * $signed({{16{off[17]}}, off});
      end
    end
  end

  always_comb begin
    logic [2:0]  kb;
    logic [16:0] wz;
    logic [33:0] wp;
    for (int k = 0; k < Nc; k++) begin
      kb           = 3'(k);
      wz           = kb[0] ? e_sz_q : gn3_pkg::UnitQ16 - e_sz_q;
      wp           = {17'd0, e_wxy_q[k]} * {17'd0, wz} + 34'h8000;
      f_d.weight[k] = wp[32:16];
      f_d.dot[k]    = {{2{e_prod_q[k][0][33]}}, e_prod_q[k][0]} +
                      {{2{e_prod_q[k][1][33]}}, e_prod_q[k][1]} +
                      {{2{e_prod_q[k][2][33]}}, e_prod_q[k][2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else if (en_i) begin
      d_v_q <= valid_i && (data_i.req == gn3_pkg::ReqEval);
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_s_q    <= s_d;
      d_frac_q <= data_i.frac;
      for (int k = 0; k < Nc; k++) begin
        d_grad_q[k] <= grad_mem[k][gidx[k]];
        if (valid_i && data_i.req == gn3_pkg::ReqLoadGrad) begin
          grad_mem[k][data_i.index] <= data_i.grad;
        end
      end
      e_wxy_q  <= wxy_d;
      e_prod_q <= prod_d;
      e_sz_q   <= d_s_q[2];
      f_q      <= f_d;
    end
  end

  assign valid_o = f_v_q;
  assign data_o  = f_q;

  a_load_no_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && valid_i && data_i.req == gn3_pkg::ReqLoadGrad) |=> !d_v_q)
    else $error("gradient load went on as an evaluation");

endmodule

FILE: hdl/gn3_accum.sv
module gn3_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  gn3_pkg::corner_t  data_i,
  output logic              valid_o,
  output logic [15:0]       level_o
);

  localparam int unsigned Nc = gn3_pkg::Corners;

  logic                g_v_q;
  logic [Nc-1:0][53:0] g_term_q;
  logic                h_v_q;
  logic [3:0][54:0]    h_pair_q;
  logic                i_v_q;
  logic [56:0]         i_sum_q;
  logic                o_v_q;
  logic [15:0]         o_level_q;

  logic [Nc-1:0][53:0] term_d;
  logic [3:0][54:0]    pair_d;
  logic [56:0]         sum_d;
  logic [15:0]         level_d;

  always_comb begin
    logic [56:0] mag;
    logic [56:0] rnd;
    for (int k = 0; k < Nc; k++) begin
      term_d[k] = $signed({{18{data_i.dot[k][35]}}, data_i.dot[k]}) *
                  $signed({37'd0, data_i.weight[k]});
    end
    for (int j = 0; j < 4; j++) begin
      pair_d[j] = {g_term_q[2*j][53], g_term_q[2*j]} +
                  {g_term_q[2*j+1][53], g_term_q[2*j+1]};
    end
    sum_d = {{2{h_pair_q[0][54]}}, h_pair_q[0]} + {{2{h_pair_q[1][54]}}, h_pair_q[1]} +
            {{2{h_pair_q[2][54]}}, h_pair_q[2]} + {{2{h_pair_q[3][54]}}, h_pair_q[3]};
    mag = i_sum_q[56] ? (57'd0 - i_sum_q) : i_sum_q;
    rnd = mag + 57'h4000_0000;
    // round Q.46 to Q1.15 and saturate
    level_d = (|rnd[56:47]) ? 16'hFFFF : rnd[46:31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en_i) begin
      g_v_q <= valid_i;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
      o_v_q <= i_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_term_q  <= term_d;
      h_pair_q  <= pair_d;
      i_sum_q   <= sum_d;
      o_level_q <= level_d;
    end
  end

  assign valid_o = o_v_q;
  assign level_o = o_level_q;

  a_out_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(o_v_q) |-> $past(i_v_q))
    else $error("result appeared without a summed item behind it");

endmodule

FILE: hdl/gradient_noise_3d_unit.sv
// channel       dir  handshake                   payload
// s_axis        in   s_axis_tvalid/tready        tuser req_type, tdata table/point fields
// m_axis        out  m_axis_tvalid/tready        tdata noise_level
// apb           in   psel/penable/pwrite/pready  point_scale at byte address 0
//
// one transaction per cycle is taken while the pipeline advances; an evaluation result
// reaches the output register after its transaction is accepted (ten register stages)
// loads give no result; they write the tables in the stage where reads happen
// the whole pipeline advances only when the output register is empty or taken
// reset clears valid bits, sets point_scale to 24'h01_0000; tables are undefined until loaded
module gradient_noise_3d_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // index[7:0] entry[15:8] grad_x[31:16] grad_y[47:32] grad_z[63:48]
  // point_x[95:64] point_y[127:96] point_z[159:128]
  input  logic [159:0] s_axis_tdata_i,
  // req_type[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // noise_level[15:0]
  output logic [15:0]  m_axis_tdata_o,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);

  logic [23:0]       scale_q;
  logic              en;
  gn3_pkg::item_t    item;
  logic              front_v;
  gn3_pkg::front_t   front_data;
  logic              corner_v;
  gn3_pkg::corner_t  corner_data;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == gn3_pkg::RegPointScale) ? {8'd0, scale_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= gn3_pkg::ScaleReset;
    end else if (psel_i && penable_i && pwrite_i &&
                 paddr_i[2] == gn3_pkg::RegPointScale) begin
      scale_q <= pwdata_i[23:0];
    end
  end

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign item.req        = s_axis_tuser_i;
  assign item.index      = s_axis_tdata_i[7:0];
  assign item.entry      = s_axis_tdata_i[15:8];
  assign item.grad.x     = s_axis_tdata_i[31:16];
  assign item.grad.y     = s_axis_tdata_i[47:32];
  assign item.grad.z     = s_axis_tdata_i[63:48];
  assign item.point[0]   = s_axis_tdata_i[95:64];
  assign item.point[1]   = s_axis_tdata_i[127:96];
  assign item.point[2]   = s_axis_tdata_i[159:128];

  gn3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .item_i  (item),
    .scale_i (scale_q),
    .valid_o (front_v),
    .data_o  (front_data)
  );

  gn3_corner u_corner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .data_i  (front_data),
    .valid_o (corner_v),
    .data_o  (corner_data)
  );

  gn3_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (corner_v),
    .data_i  (corner_data),
    .valid_o (m_axis_tvalid_o),
    .level_o (m_axis_tdata_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with an empty output register");

endmodule
